[rtl/core/gjdu_pkg.sv]
// Shared types, constants and table functions of the Gregorian/Julian date unit.
`default_nettype none
package gjdu_pkg;

	localparam logic [1:0] REQ_SET_DATE = 2'd0;
	localparam logic [1:0] REQ_SET_JDN  = 2'd1;
	localparam logic [1:0] REQ_ADD_DAYS = 2'd2;
	localparam logic [1:0] REQ_CHECK    = 2'd3;

	localparam int DIV_W  = 28;
	localparam int QUO_W  = 9;
	localparam int RCP_W  = 26;
	localparam int DSR_W  = 21;
	localparam int QEST_W = 22;
	localparam int RCP_SH = 32;

	localparam logic [22:0] JDN_MAX     = 23'd8388607;
	localparam logic [23:0] JDN_BIAS    = 24'd68569;
	localparam logic [22:0] JDN_EPOCH   = 23'd1721119;
	localparam logic [22:0] JDN_YEAR_M1 = 23'd1720754;
	localparam logic [14:0] YEAR_MAX    = 15'd9999;
	localparam logic [13:0] RESET_YEAR  = 14'd2000;
	localparam logic [3:0]  RESET_MONTH = 4'd1;
	localparam logic [4:0]  RESET_DAY   = 5'd1;
	localparam logic [22:0] RESET_JDN   = 23'd2451545;

	typedef enum logic [2:0] {
		DV_N,
		DV_I,
		DV_J,
		DV_D,
		DV_Y
	} div_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_L2A,
		OP_L2B,
		OP_L3A,
		OP_L3B,
		OP_JCAP,
		OP_YMD,
		OP_JA,
		OP_JB,
		OP_COMMIT,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_N_GO,
		S_N_WT,
		S_L2A,
		S_L2B,
		S_I_GO,
		S_I_WT,
		S_L3A,
		S_L3B,
		S_J_GO,
		S_J_WT,
		S_D_GO,
		S_D_WT,
		S_YMD,
		S_Y_GO,
		S_Y_WT,
		S_JA,
		S_JB,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t   op;
		logic     div_start;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic bad;
	} dp_sts_t;

	// Reciprocal of the divisor scaled by two to the power RCP_SH, rounded down.
	function automatic logic [RCP_W-1:0] div_recip(input div_sel_t sel);
		logic [RCP_W-1:0] r;
		case (sel)
			DV_N:    r = 26'd29398;
			DV_I:    r = 26'd2939;
			DV_J:    r = 26'd1755197;
			DV_D:    r = 26'd53687091;
			DV_Y:    r = 26'd42949672;
			default: r = 26'd42949672;
		endcase
		return r;
	endfunction

	function automatic logic [DSR_W-1:0] div_divisor(input div_sel_t sel);
		logic [DSR_W-1:0] r;
		case (sel)
			DV_N:    r = 21'd146097;
			DV_I:    r = 21'd1461001;
			DV_J:    r = 21'd2447;
			DV_D:    r = 21'd80;
			DV_Y:    r = 21'd100;
			default: r = 21'd100;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd2:                      r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        r = 5'd31;
			default:                   r = 5'd0;
		endcase
		return r;
	endfunction

	// Days before the month with March as the first month of the year.
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Since eight is one more than seven, octal digits fold the value modulo seven.
	function automatic logic [2:0] weekday_of(input logic [22:0] jdn);
		logic [23:0] x;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [3:0]  s3;
		x  = {1'b0, jdn} + 24'd1;
		s1 = 6'd0;
		for (int k = 0; k < 8; k++) begin
			s1 = s1 + {3'b000, x[3*k +: 3]};
		end
		s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
		s3 = {3'b000, s2[3]} + {1'b0, s2[2:0]};
		if (s3 >= 4'd7) begin
			s3 = s3 - 4'd7;
		end
		return s3[2:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/gjdu_div.sv]
// Divider by a selected constant: reciprocal multiply, remainder and one correction step.
`default_nettype none
module gjdu_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire gjdu_pkg::div_sel_t          sel,
	input  wire logic [gjdu_pkg::DIV_W-1:0]  dividend,
	output logic                             busy,
	output logic [gjdu_pkg::QUO_W-1:0]       quo,
	output logic [gjdu_pkg::DIV_W-1:0]       rem
);
	import gjdu_pkg::*;

	logic [DIV_W-1:0]  x_q;
	logic [RCP_W-1:0]  rcp_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QEST_W-1:0] qe_q;
	logic [DIV_W-1:0]  r0_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [1:0]        ph_q;
	logic              busy_q;
	logic [QEST_W-1:0] qe;
	logic [DIV_W-1:0]  dsr_ext;
	logic [DIV_W-1:0]  qd;
	logic              ge;

	// The estimate is the true quotient or one less, so a single correction suffices.
	assign qe      = QEST_W'(({{RCP_W{1'b0}}, x_q} * {{DIV_W{1'b0}}, rcp_q}) >> RCP_SH);
	assign dsr_ext = {{(DIV_W-DSR_W){1'b0}}, dsr_q};
	assign qd      = {{(DIV_W-QEST_W){1'b0}}, qe_q} * dsr_ext;
	assign ge      = (r0_q >= dsr_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= '0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd2) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			rcp_q <= div_recip(sel);
			dsr_q <= div_divisor(sel);
		end else if (busy_q) begin
			case (ph_q)
				2'd0: qe_q <= qe;
				2'd1: r0_q <= x_q - qd;
				default: begin
					quo_q <= ge ? QUO_W'(qe_q + QEST_W'(1)) : QUO_W'(qe_q);
					rem_q <= ge ? (r0_q - dsr_ext) : r0_q;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

[rtl/core/gjdu_dp.sv]
// Datapath: date state, conversion registers, shared divider and result register.
`default_nettype none
module gjdu_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gjdu_pkg::dp_cmd_t    cmd,
	output gjdu_pkg::dp_sts_t         sts,
	input  wire logic [1:0]           req_type,
	input  wire logic [13:0]          year_in,
	input  wire logic [3:0]           month_in,
	input  wire logic [4:0]           day_in,
	input  wire logic [22:0]          julian_in,
	input  wire logic signed [22:0]   day_offset,
	output logic                      status,
	output logic [13:0]               year_out,
	output logic [3:0]                month_out,
	output logic [4:0]                day_out,
	output logic [22:0]               julian_out,
	output logic [2:0]                weekday
);
	import gjdu_pkg::*;

	logic [13:0] cur_year_q;
	logic [3:0]  cur_month_q;
	logic [4:0]  cur_day_q;
	logic [22:0] cur_julian_q;

	logic        bad_q;
	logic        ok_q;
	logic [23:0] l_q;
	logic [25:0] t_q;
	logic [7:0]  n_q;
	logic [6:0]  i_q;
	logic [3:0]  j_q;
	logic [15:0] y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [22:0] acc_q;
	logic [7:0]  qp_q;
	logic [11:0] yp4_q;
	logic [22:0] jdn_q;

	logic [DIV_W-1:0] div_a;
	logic             div_busy;
	logic [QUO_W-1:0] quo;
	logic [DIV_W-1:0] rem;

	logic signed [24:0] jd_sum;
	logic [22:0] jd_sel;
	logic        jd_bad;
	logic        l4;
	logic [8:0]  nm;
	logic        r0;
	logic        ok_y;
	logic        leap;
	logic [4:0]  len;
	logic        ok_c;
	logic        adj;
	logic        yneg;
	logic [13:0] yp;
	logic [7:0]  qp_c;

	gjdu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sel      (cmd.div_sel),
		.dividend (div_a),
		.busy     (div_busy),
		.quo      (quo),
		.rem      (rem)
	);

	always_comb begin
		case (cmd.div_sel)
			DV_N:    div_a = {2'b00, l_q, 2'b00};
			DV_I:    div_a = ({11'd0, l_q[16:0]} + 28'd1) * 28'd4000;
			DV_J:    div_a = {18'd0, l_q[9:0]} * 28'd80;
			DV_D:    div_a = {24'd0, quo[3:0]} * 28'd2447;
			DV_Y:    div_a = {14'd0, y_q[13:0]};
			default: div_a = '0;
		endcase
	end

	always_comb begin
		jd_sum = $signed({2'b00, cur_julian_q}) + $signed({{2{day_offset[22]}}, day_offset});
		jd_sel = (req_type == REQ_SET_JDN) ? julian_in : jd_sum[22:0];
		jd_bad = (req_type == REQ_ADD_DAYS) && (jd_sum[24] || jd_sum[23]);

		l4 = (j_q >= 4'd11);
		nm = {1'b0, n_q} - 9'd49;

		r0   = (rem == '0);
		ok_y = !y_q[15] && (y_q[14:0] <= YEAR_MAX);
		leap = ((y_q[1:0] == 2'b00) && !r0) || (r0 && (quo[1:0] == 2'b00));
		len  = month_len(m_q) + {4'd0, (m_q == 4'd2) && leap};
		ok_c = ok_y && (m_q >= 4'd1) && (m_q <= 4'd12) && (d_q != 5'd0) && (d_q <= len);
		adj  = (m_q < 4'd3);
		yneg = adj && (y_q[13:0] == 14'd0);
		yp   = y_q[13:0] - {13'd0, adj};
		qp_c = (adj && r0) ? (quo[7:0] - 8'd1) : quo[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q   <= RESET_YEAR;
			cur_month_q  <= RESET_MONTH;
			cur_day_q    <= RESET_DAY;
			cur_julian_q <= RESET_JDN;
			bad_q        <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: bad_q <= jd_bad;
				OP_JA:      ok_q  <= ok_c;
				OP_COMMIT: begin
					if (ok_q && !bad_q) begin
						cur_year_q   <= y_q[13:0];
						cur_month_q  <= m_q;
						cur_day_q    <= d_q;
						cur_julian_q <= jdn_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				y_q <= {2'b00, year_in};
				m_q <= month_in;
				d_q <= day_in;
				l_q <= {1'b0, jd_sel} + JDN_BIAS;
			end
			OP_L2A: begin
				n_q <= quo[7:0];
				t_q <= {18'd0, quo[7:0]} * 26'd146097 + 26'd3;
			end
			OP_L2B: l_q <= l_q - t_q[25:2];
			OP_L3A: begin
				i_q <= quo[6:0];
				t_q <= {19'd0, quo[6:0]} * 26'd1461;
			end
			OP_L3B: l_q <= l_q - t_q[25:2] + 24'd31;
			OP_JCAP: j_q <= quo[3:0];
			OP_YMD: begin
				d_q <= l_q[4:0] - quo[4:0];
				m_q <= j_q + 4'd2 - (l4 ? 4'd12 : 4'd0);
				y_q <= {{7{nm[8]}}, nm} * 16'd100 + {9'd0, i_q} + {15'd0, l4};
			end
			OP_JA: begin
				acc_q <= yneg ? JDN_YEAR_M1 : ({9'd0, yp} * 23'd365 + JDN_EPOCH);
				qp_q  <= yneg ? 8'd0 : qp_c;
				yp4_q <= yneg ? 12'd0 : yp[13:2];
			end
			OP_JB: begin
				jdn_q <= acc_q + {18'd0, d_q} + {14'd0, month_term(m_q)} + {11'd0, yp4_q}
					- {15'd0, qp_q} + {17'd0, qp_q[7:2]};
			end
			OP_FINISH: begin
				status     <= bad_q || !ok_q;
				year_out   <= cur_year_q;
				month_out  <= cur_month_q;
				day_out    <= cur_day_q;
				julian_out <= cur_julian_q;
				weekday    <= weekday_of(cur_julian_q);
			end
			default: ;
		endcase
	end

	assign sts.div_busy = div_busy;
	assign sts.bad      = bad_q;
endmodule
`default_nettype wire

[rtl/core/gjdu_ctrl.sv]
// Controller: sequences one request through the datapath and owns the handshakes.
`default_nettype none
module gjdu_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output gjdu_pkg::dp_cmd_t       cmd,
	input  wire gjdu_pkg::dp_sts_t  sts
);
	import gjdu_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] req_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_SET_JDN || req_type == REQ_ADD_DAYS) begin
						state_d = S_N_GO;
					end else begin
						state_d = S_Y_GO;
					end
				end
			end
			S_N_GO:   state_d = sts.bad ? S_DONE : S_N_WT;
			S_N_WT:   state_d = sts.div_busy ? S_N_WT : S_L2A;
			S_L2A:    state_d = S_L2B;
			S_L2B:    state_d = S_I_GO;
			S_I_GO:   state_d = S_I_WT;
			S_I_WT:   state_d = sts.div_busy ? S_I_WT : S_L3A;
			S_L3A:    state_d = S_L3B;
			S_L3B:    state_d = S_J_GO;
			S_J_GO:   state_d = S_J_WT;
			S_J_WT:   state_d = sts.div_busy ? S_J_WT : S_D_GO;
			S_D_GO:   state_d = S_D_WT;
			S_D_WT:   state_d = sts.div_busy ? S_D_WT : S_YMD;
			S_YMD:    state_d = S_Y_GO;
			S_Y_GO:   state_d = S_Y_WT;
			S_Y_WT:   state_d = sts.div_busy ? S_Y_WT : S_JA;
			S_JA:     state_d = S_JB;
			S_JB:     state_d = (req_q == REQ_CHECK) ? S_DONE : S_COMMIT;
			S_COMMIT: state_d = S_DONE;
			S_DONE:   state_d = slot_free ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DV_N;
		unique case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
			S_N_GO:   cmd.div_start = !sts.bad;
			S_L2A:    cmd.op = OP_L2A;
			S_L2B:    cmd.op = OP_L2B;
			S_I_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_I;
			end
			S_L3A:    cmd.op = OP_L3A;
			S_L3B:    cmd.op = OP_L3B;
			S_J_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_J;
			end
			S_D_GO: begin
				cmd.op        = OP_JCAP;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_D;
			end
			S_YMD:    cmd.op = OP_YMD;
			S_Y_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_Y;
			end
			S_JA:     cmd.op = OP_JA;
			S_JB:     cmd.op = OP_JB;
			S_COMMIT: cmd.op = OP_COMMIT;
			S_DONE:   cmd.op = slot_free ? OP_FINISH : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= REQ_SET_DATE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid) begin
				req_q <= req_type;
			end
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[rtl/core/gregorian_julian_date_unit.sv]
// One transaction is in work at a time and the next is taken in the cycle after a result is
// loaded; each constant division uses the shared reciprocal divider, and a day addition that
// leaves the range skips the conversion and goes straight to its result.
// A result waits in its own register; one still waiting holds the next result back.
// Reset (asynchronous, active low) gives 2000-01-01, Julian day 2451545, no result pending.
`default_nettype none
module gregorian_julian_date_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [13:0]        year_in,
	input  wire logic [3:0]         month_in,
	input  wire logic [4:0]         day_in,
	input  wire logic [22:0]        julian_in,
	input  wire logic signed [22:0] day_offset,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    status,
	output logic [13:0]             year_out,
	output logic [3:0]              month_out,
	output logic [4:0]              day_out,
	output logic [22:0]             julian_out,
	output logic [2:0]              weekday
);
	import gjdu_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gjdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	gjdu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.year_in    (year_in),
		.month_in   (month_in),
		.day_in     (day_in),
		.julian_in  (julian_in),
		.day_offset (day_offset),
		.status     (status),
		.year_out   (year_out),
		.month_out  (month_out),
		.day_out    (day_out),
		.julian_out (julian_out),
		.weekday    (weekday)
	);

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result raised right after acceptance");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_out >= 4'd1 && month_out <= 4'd12 && weekday <= 3'd6
			&& day_out != 5'd0))
		else $error("result date out of range");
`endif
endmodule
`default_nettype wire

[tb/tb_gregorian_julian_date_unit.sv]
// Self-checking testbench of the Gregorian/Julian date unit with a date predictor.
`timescale 1ns / 1ps
module tb_gregorian_julian_date_unit;
	import gjdu_pkg::*;

	typedef struct {
		logic [1:0]         req;
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [22:0]        jdn;
		logic signed [22:0] offset;
	} date_req_t;

	typedef struct {
		logic        status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [22:0] jdn;
		logic [2:0]  weekday;
	} date_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_SET_DATE;
	logic [13:0] year_in = '0;
	logic [3:0] month_in = '0;
	logic [4:0] day_in = '0;
	logic [22:0] julian_in = '0;
	logic signed [22:0] day_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [13:0] year_out;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic [22:0] julian_out;
	logic [2:0] weekday;

	date_req_t pending_reqs[$];
	date_res_t expected_dates[$];
	date_req_t driven_req;
	int errors = 0;

	longint model_year = 2000;
	longint model_month = 1;
	longint model_day = 1;
	longint model_jdn = 2451545;

	gregorian_julian_date_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .year_in(year_in), .month_in(month_in), .day_in(day_in),
		.julian_in(julian_in), .day_offset(day_offset), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .year_out(year_out),
		.month_out(month_out), .day_out(day_out), .julian_out(julian_out),
		.weekday(weekday)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit is_leap(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_in_month(longint y, longint m);
		longint len;
		len = month_len(m[3:0]);
		if (m == 2 && is_leap(y)) begin
			len++;
		end
		return len;
	endfunction

	function automatic bit valid_date(longint y, longint m, longint d);
		if (y < 0 || y > 9999 || m < 1 || m > 12) begin
			return 1'b0;
		end
		return d >= 1 && d <= days_in_month(y, m);
	endfunction

	function automatic longint ymd_to_jdn(longint y, longint m, longint d);
		if (m < 3) begin
			m += 12;
			y -= 1;
		end
		return d + (153 * m - 457) / 5 + 365 * y + y / 4 - y / 100 + y / 400 + 1721119;
	endfunction

	function automatic logic commit_date(longint y, longint m, longint d);
		if (!valid_date(y, m, d)) begin
			return 1'b1;
		end
		model_year = y;
		model_month = m;
		model_day = d;
		model_jdn = ymd_to_jdn(y, m, d) & 64'h7FFFFF;
		return 1'b0;
	endfunction

	function automatic logic commit_jdn(longint jd);
		longint l, n, i, j, dd, mm, yy;
		if (jd < 0 || jd > 8388607) begin
			return 1'b1;
		end
		l = jd + 68569;
		n = (4 * l) / 146097;
		l = l - (146097 * n + 3) / 4;
		i = (4000 * (l + 1)) / 1461001;
		l = l - (1461 * i) / 4 + 31;
		j = (80 * l) / 2447;
		dd = l - (2447 * j) / 80;
		l = j / 11;
		mm = j + 2 - 12 * l;
		yy = 100 * (n - 49) + i + l;
		return commit_date(yy, mm, dd);
	endfunction

	function automatic date_res_t apply_date_req(date_req_t r);
		date_res_t res;
		longint off;
		off = r.offset;
		case (r.req)
			REQ_SET_DATE: res.status = commit_date(r.year, r.month, r.day);
			REQ_SET_JDN:  res.status = commit_jdn(r.jdn);
			REQ_ADD_DAYS: res.status = commit_jdn(model_jdn + off);
			default:      res.status = !valid_date(r.year, r.month, r.day);
		endcase
		res.year = model_year[13:0];
		res.month = model_month[3:0];
		res.day = model_day[4:0];
		res.jdn = model_jdn[22:0];
		res.weekday = 3'((model_jdn + 1) % 7);
		return res;
	endfunction

	function automatic date_req_t make_req(logic [1:0] t, int y, int m, int d,
			int jd, int off);
		date_req_t r;
		r.req = t;
		r.year = y[13:0];
		r.month = m[3:0];
		r.day = d[4:0];
		r.jdn = jd[22:0];
		r.offset = off[22:0];
		return r;
	endfunction

	function automatic date_req_t random_req();
		date_req_t r;
		int y, m, k;
		r.req = 2'($urandom_range(0, 3));
		r.jdn = 23'($urandom);
		r.offset = 23'($urandom);
		r.year = 14'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		k = $urandom_range(0, 9);
		if (k < 8) begin
			y = $urandom_range(0, 9999);
			m = $urandom_range(1, 12);
			r.year = y[13:0];
			r.month = m[3:0];
			r.day = 5'($urandom_range(1, days_in_month(y, m)));
			if (k < 2) begin
				r.day = 5'($urandom_range(28, 31));
			end
			r.jdn = 23'($urandom_range(1721060, 5373484));
			if (k < 5) begin
				r.offset = 23'($urandom_range(0, 4000) - 2000);
			end else if (k < 7) begin
				r.offset = 23'($urandom_range(0, 2000000) - 1000000);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int gap_left;
		int burst_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			burst_left = 1;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_dates.push_back(apply_date_req(driven_req));
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				driven_req = pending_reqs.pop_front();
				req_type <= driven_req.req;
				year_in <= driven_req.year;
				month_in <= driven_req.month;
				day_in <= driven_req.day;
				julian_in <= driven_req.jdn;
				day_offset <= driven_req.offset;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int cycle_cnt;
		int stall_mode;
		date_res_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
			cycle_cnt = 0;
			stall_mode = 0;
		end else begin
			cycle_cnt++;
			if (cycle_cnt % 97 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= (cycle_cnt % 8 < 3);
			endcase
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$error("unexpected transaction on the result side");
					errors++;
				end else begin
					exp_res = expected_dates.pop_front();
					if (status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, status);
						errors++;
					end
					if (year_out !== exp_res.year) begin
						$error("year_out: expected %0d, got %0d", exp_res.year, year_out);
						errors++;
					end
					if (month_out !== exp_res.month) begin
						$error("month_out: expected %0d, got %0d", exp_res.month, month_out);
						errors++;
					end
					if (day_out !== exp_res.day) begin
						$error("day_out: expected %0d, got %0d", exp_res.day, day_out);
						errors++;
					end
					if (julian_out !== exp_res.jdn) begin
						$error("julian_out: expected %0d, got %0d", exp_res.jdn, julian_out);
						errors++;
					end
					if (weekday !== exp_res.weekday) begin
						$error("weekday: expected %0d, got %0d", exp_res.weekday, weekday);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		pending_reqs.push_back(make_req(REQ_CHECK, 2000, 2, 29, 0, 0));
		pending_reqs.push_back(make_req(REQ_CHECK, 1900, 2, 29, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2024, 2, 29, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2023, 2, 29, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 0, 1, 1, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 0, 2, 29, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 9999, 12, 31, 0, 0));
		pending_reqs.push_back(make_req(REQ_ADD_DAYS, 0, 0, 0, 0, 1));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 10000, 1, 1, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 16383, 15, 31, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2001, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2001, 13, 1, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2001, 4, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_DATE, 2001, 4, 31, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_JDN, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_SET_JDN, 0, 0, 0, 8388607, 0));
		pending_reqs.push_back(make_req(REQ_SET_JDN, 0, 0, 0, 1721060, 0));
		pending_reqs.push_back(make_req(REQ_SET_JDN, 0, 0, 0, 5373484, 0));
		pending_reqs.push_back(make_req(REQ_SET_JDN, 0, 0, 0, 5373485, 0));
		pending_reqs.push_back(make_req(REQ_ADD_DAYS, 0, 0, 0, 0, -4194304));
		pending_reqs.push_back(make_req(REQ_ADD_DAYS, 0, 0, 0, 0, 4194303));
		pending_reqs.push_back(make_req(REQ_ADD_DAYS, 0, 0, 0, 0, -1000000));
		pending_reqs.push_back(make_req(REQ_CHECK, 16383, 15, 31, 0, 0));
		pending_reqs.push_back(make_req(REQ_CHECK, 0, 1, 1, 0, 0));
		for (int n = 0; n < 1400; n++) begin
			pending_reqs.push_back(random_req());
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !in_valid && expected_dates.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_dates.size() == 0) begin
			$display("gregorian_julian_date_unit test passed");
		end else begin
			$display("gregorian_julian_date_unit test failed");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("gregorian_julian_date_unit test failed");
		$finish;
	end

endmodule
